// File: design/obm_pkg.sv
package obm_pkg;

  // Default table size and hard limit on entries searched by one match
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int WALK_LIMIT      = 16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_MATCH = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  entry_index;
    logic        side;
    logic [15:0] product_id;
    logic [23:0] price;
    logic [15:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic        is_summary;
    logic [3:0]  matched_entry;
    logic [15:0] fill_quantity;
    logic        entry_fulfilled;
    logic [15:0] remaining_quantity;
    logic        order_fulfilled;
    logic        last;
  } out_item_t;

  // One resting order in the table
  typedef struct packed {
    logic        side;
    logic [15:0] product;
    logic [23:0] price;
    logic [15:0] quantity;
  } entry_t;

  // Outcome of testing one resting order against the new order
  typedef struct packed {
    logic        hit;
    logic [15:0] fill;
    logic [15:0] entry_rem;
    logic [15:0] order_rem;
  } fill_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

// File: design/obm_table.sv
module obm_table #(
  parameter int DEPTH = obm_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  obm_pkg::entry_t       wdata,
  input  logic [AW-1:0]         raddr,
  output obm_pkg::entry_t       rdata
);

  obm_pkg::entry_t  mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // Mark entries written since reset; unwritten entries read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we && (int'(waddr) < DEPTH)) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Write one entry
  always_ff @(posedge clk) begin
    if (we && (int'(waddr) < DEPTH)) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if ((int'(raddr) < DEPTH) && valid[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule

// File: design/obm_fill.sv
module obm_fill (
  input  obm_pkg::entry_t   entry,
  input  logic              ord_side,
  input  logic [15:0]       ord_product,
  input  logic [23:0]       ord_price,
  input  logic [15:0]       ord_rem,
  output obm_pkg::fill_res_t res
);

  logic        price_ok;
  logic [15:0] fill;

  // A buy crosses at or above the resting price, a sell at or below
  assign price_ok = (ord_side == obm_pkg::SIDE_BUY) ? (ord_price >= entry.price)
                                                    : (ord_price <= entry.price);

  assign fill = (ord_rem < entry.quantity) ? ord_rem : entry.quantity;

  // Skip empty entries, same side and other products
  always_comb begin
    res.hit       = (entry.quantity != 16'd0) && (entry.side != ord_side) &&
                    (entry.product == ord_product) && price_ok;
    res.fill      = fill;
    res.entry_rem = entry.quantity - fill;
    res.order_rem = ord_rem - fill;
  end

endmodule

// File: design/order_book_match_unit.sv
// Load beat: taken with no result; busy stays low.
// Match beat: busy from the accepting edge through the walk, which tests one table entry
// a cycle for n = min(entries_in_use, TABLE_DEPTH, 16) entries (fewer once the order is
// filled), and through the summary step that closes it.
// Each result is registered and shows in the cycle after the one that builds it; the summary comes as busy
// falls and the receiver cannot stall. Synchronous reset empties table and entries_in_use.
module order_book_match_unit #(
  parameter int TABLE_DEPTH = obm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  obm_pkg::in_item_t   item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  output logic                result_valid,
  output obm_pkg::out_item_t  result
);

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WALKMAX = (TABLE_DEPTH < obm_pkg::WALK_LIMIT) ? TABLE_DEPTH
                                                               : obm_pkg::WALK_LIMIT;

  obm_pkg::state_t    state, state_next;
  logic [4:0]         entries_in_use;
  logic [4:0]         idx, idx_next;
  logic [4:0]         n_lim, n_lim_next;
  logic               ord_side;
  logic [15:0]        ord_product;
  logic [23:0]        ord_price;
  logic [15:0]        rem, rem_next;
  logic [15:0]        total, total_next;
  logic               emit;
  obm_pkg::out_item_t res_next;
  logic               accept_match;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  obm_pkg::entry_t    tbl_wdata;
  logic [AW-1:0]      tbl_raddr;
  obm_pkg::entry_t    tbl_rdata;
  obm_pkg::fill_res_t fres;

  obm_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  obm_fill u_fill (
    .entry       (tbl_rdata),
    .ord_side    (ord_side),
    .ord_product (ord_product),
    .ord_price   (ord_price),
    .ord_rem     (rem),
    .res         (fres)
  );

  assign busy         = (state != obm_pkg::ST_IDLE);
  assign accept_match = (state == obm_pkg::ST_IDLE) && start &&
                        (item.mode == obm_pkg::MODE_MATCH);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  // Sequencer: next state, table access and result
  always_comb begin
    state_next = state;
    idx_next   = idx;
    n_lim_next = n_lim;
    rem_next   = rem;
    total_next = total;
    emit       = 1'b0;
    res_next   = result;
    tbl_we     = 1'b0;
    tbl_waddr  = AW'(idx);
    tbl_wdata  = tbl_rdata;
    tbl_wdata.quantity = fres.entry_rem;
    tbl_raddr  = AW'(idx + 5'd1);
    case (state)
      obm_pkg::ST_IDLE: begin
        if (start) begin
          if (item.mode == obm_pkg::MODE_MATCH) begin
            state_next = obm_pkg::ST_WALK;
            idx_next   = '0;
            tbl_raddr  = '0;
            rem_next   = item.quantity;
            total_next = '0;
            n_lim_next = (int'(entries_in_use) > WALKMAX) ? 5'(WALKMAX) : entries_in_use;
          end else if (int'(item.entry_index) < TABLE_DEPTH) begin
            tbl_we             = 1'b1;
            tbl_waddr          = AW'(item.entry_index);
            tbl_wdata.side     = item.side;
            tbl_wdata.product  = item.product_id;
            tbl_wdata.price    = item.price;
            tbl_wdata.quantity = item.quantity;
          end
        end
      end
      obm_pkg::ST_WALK: begin
        if ((idx < n_lim) && (rem != 16'd0)) begin
          // Test one entry, fill and write back on a hit
          idx_next = idx + 5'd1;
          if (fres.hit) begin
            tbl_we                      = 1'b1;
            emit                        = 1'b1;
            rem_next                    = fres.order_rem;
            total_next                  = total + fres.fill;
            res_next.is_summary         = 1'b0;
            res_next.matched_entry      = idx[3:0];
            res_next.fill_quantity      = fres.fill;
            res_next.entry_fulfilled    = (fres.entry_rem == 16'd0);
            res_next.remaining_quantity = fres.order_rem;
            res_next.order_fulfilled    = (fres.order_rem == 16'd0);
            res_next.last               = 1'b0;
          end
        end else begin
          // Close the match with the summary beat
          state_next                  = obm_pkg::ST_IDLE;
          emit                        = 1'b1;
          res_next.is_summary         = 1'b1;
          res_next.matched_entry      = '0;
          res_next.fill_quantity      = total;
          res_next.entry_fulfilled    = 1'b0;
          res_next.remaining_quantity = rem;
          res_next.order_fulfilled    = (rem == 16'd0);
          res_next.last               = 1'b1;
        end
      end
      default: begin
        state_next = obm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= obm_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
    end
  end

  // Walk and order registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    n_lim  <= n_lim_next;
    rem    <= rem_next;
    total  <= total_next;
    result <= res_next;
    if (accept_match) begin
      ord_side    <= item.side;
      ord_product <= item.product_id;
      ord_price   <= item.price;
    end
  end

endmodule

// File: sim/tb_order_book_match_unit.sv
// Tracks the resting-order table and the walk span, predicts the fills and the
// closing summary of every match beat, and checks results in arrival order.
class book_checker;
  logic                   side_book  [obm_pkg::TABLE_DEPTH_DEF];
  logic [15:0]            prod_book  [obm_pkg::TABLE_DEPTH_DEF];
  logic [23:0]            price_book [obm_pkg::TABLE_DEPTH_DEF];
  logic [15:0]            qty_book   [obm_pkg::TABLE_DEPTH_DEF];
  logic [4:0]             walk_span;
  obm_pkg::out_item_t     due_results[$];
  int                     errors;
  int                     loads;
  int                     match_count;
  int                     fills;
  int                     filled_orders;

  function new();
    for (int i = 0; i < obm_pkg::TABLE_DEPTH_DEF; i++) begin
      side_book[i]  = 1'b0;
      prod_book[i]  = '0;
      price_book[i] = '0;
      qty_book[i]   = '0;
    end
    walk_span = '0;
    errors = 0;
    loads = 0;
    match_count = 0;
    fills = 0;
    filled_orders = 0;
  endfunction

  // Apply one accepted beat: store a load, or walk the table for a match
  function void take_order(obm_pkg::in_item_t it);
    logic [15:0]        left;
    logic [15:0]        fill;
    logic [15:0]        total;
    int                 span;
    obm_pkg::out_item_t r;
    if (it.mode == obm_pkg::MODE_LOAD) begin
      side_book[it.entry_index]  = it.side;
      prod_book[it.entry_index]  = it.product_id;
      price_book[it.entry_index] = it.price;
      qty_book[it.entry_index]   = it.quantity;
      loads++;
      return;
    end
    match_count++;
    span = int'(walk_span);
    if (span > obm_pkg::TABLE_DEPTH_DEF) span = obm_pkg::TABLE_DEPTH_DEF;
    if (span > obm_pkg::WALK_LIMIT) span = obm_pkg::WALK_LIMIT;
    left = it.quantity;
    total = '0;
    for (int i = 0; i < span && left != 0; i++) begin
      // skip empty entries, same side and other products
      if (qty_book[i] == 0 || side_book[i] == it.side || prod_book[i] != it.product_id)
        continue;
      if (it.side == obm_pkg::SIDE_BUY ? (it.price < price_book[i])
                                       : (it.price > price_book[i]))
        continue;
      fill = (left < qty_book[i]) ? left : qty_book[i];
      left = left - fill;
      qty_book[i] = qty_book[i] - fill;
      total = total + fill;
      r = '0;
      r.matched_entry      = 4'(i);
      r.fill_quantity      = fill;
      r.entry_fulfilled    = (qty_book[i] == 0);
      r.remaining_quantity = left;
      r.order_fulfilled    = (left == 0);
      due_results.push_back(r);
      fills++;
    end
    // close with the summary beat
    r = '0;
    r.is_summary         = 1'b1;
    r.fill_quantity      = total;
    r.remaining_quantity = left;
    r.order_fulfilled    = (left == 0);
    r.last               = 1'b1;
    due_results.push_back(r);
    if (left == 0) filled_orders++;
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Check one result beat against the oldest outstanding prediction
  function void check_fill(obm_pkg::out_item_t got);
    obm_pkg::out_item_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result beat with nothing outstanding, actual %h", $time, got);
      errors++;
      return;
    end
    want = due_results.pop_front();
    compare_field("is_summary", 32'(want.is_summary), 32'(got.is_summary));
    compare_field("matched_entry", 32'(want.matched_entry), 32'(got.matched_entry));
    compare_field("fill_quantity", 32'(want.fill_quantity), 32'(got.fill_quantity));
    compare_field("entry_fulfilled", 32'(want.entry_fulfilled), 32'(got.entry_fulfilled));
    compare_field("remaining_quantity", 32'(want.remaining_quantity),
                  32'(got.remaining_quantity));
    compare_field("order_fulfilled", 32'(want.order_fulfilled), 32'(got.order_fulfilled));
    compare_field("last", 32'(want.last), 32'(got.last));
  endfunction
endclass

module tb_order_book_match_unit;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 30;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  obm_pkg::in_item_t  item = '0;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_wdata = '0;
  logic               result_valid;
  obm_pkg::out_item_t result;

  book_checker book;
  int          cycle_count = 0;
  logic [15:0] prod_pool [2];
  logic [23:0] price_base;

  order_book_match_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch accepted beats, result beats and register writes at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) book.check_fill(result);
      if (start && !busy) book.take_order(item);
      if (cfg_we) book.walk_span = cfg_wdata;
    end
  end

  // Give up if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Some tests failed");
    $finish;
  end

  function automatic obm_pkg::in_item_t order_beat(logic mode, logic [3:0] idx, logic side,
                                                   logic [15:0] prod, logic [23:0] price,
                                                   logic [15:0] qty);
    obm_pkg::in_item_t it;
    it.mode        = mode;
    it.entry_index = idx;
    it.side        = side;
    it.product_id  = prod;
    it.price       = price;
    it.quantity    = qty;
    return it;
  endfunction

  // Mostly orders on the phase's products near one price, with some noise
  function automatic obm_pkg::in_item_t random_order();
    obm_pkg::in_item_t it;
    int                roll;
    it.mode        = ($urandom_range(0, 9) < 4) ? obm_pkg::MODE_LOAD : obm_pkg::MODE_MATCH;
    it.entry_index = 4'($urandom);
    it.side        = 1'($urandom);
    roll = $urandom_range(0, 9);
    it.product_id  = (roll == 0) ? 16'($urandom) : prod_pool[$urandom_range(0, 1)];
    roll = $urandom_range(0, 9);
    it.price       = (roll == 0) ? 24'($urandom) : price_base + 24'($urandom_range(0, 200));
    roll = $urandom_range(0, 19);
    if (roll == 0)
      it.quantity = '0;
    else if (roll < 3)
      it.quantity = 16'($urandom);
    else
      it.quantity = 16'($urandom_range(1, 60));
    return it;
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic send(obm_pkg::in_item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every predicted result has arrived and the block is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (book.due_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_span(logic [4:0] span);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= span;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    book = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty walk straight after reset, then a zero-quantity order
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_BUY, 16'd7, 24'd500, 16'd5));
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_SELL, 16'd7, 24'd500, 16'd0));

    // build a small book, including an entry on the far end of the table
    send(order_beat(obm_pkg::MODE_LOAD, 4'd0, obm_pkg::SIDE_SELL, 16'd7, 24'd100, 16'd10));
    send(order_beat(obm_pkg::MODE_LOAD, 4'd1, obm_pkg::SIDE_SELL, 16'd7, 24'd150, 16'd20));
    send(order_beat(obm_pkg::MODE_LOAD, 4'd2, obm_pkg::SIDE_BUY, 16'd7, 24'd120, 16'd5));
    send(order_beat(obm_pkg::MODE_LOAD, 4'd3, obm_pkg::SIDE_SELL, 16'd8, 24'd90, 16'd9));
    send(order_beat(obm_pkg::MODE_LOAD, 4'd15, obm_pkg::SIDE_SELL, 16'd7, 24'd0, 16'hFFFF));
    set_span(5'd16);

    // partial fills, a price miss, early stop and an emptied entry
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_BUY, 16'd7, 24'd120, 16'd12));
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_BUY, 16'd7, 24'hFFFFFF,
                    16'hFFFF));
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_SELL, 16'd7, 24'd0, 16'd3));
    send(order_beat(obm_pkg::MODE_MATCH, 4'd9, obm_pkg::SIDE_SELL, 16'hFFFF, 24'hFFFFFF,
                    16'd1));
    send(order_beat(obm_pkg::MODE_LOAD, 4'd4, obm_pkg::SIDE_BUY, 16'hFFFF, 24'hFFFFFF,
                    16'hFFFF));
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_SELL, 16'hFFFF, 24'hFFFFFF,
                    16'd1));
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_SELL, 16'd7, 24'd200, 16'd0));

    // oversized and minimal walk spans
    set_span(5'd31);
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_BUY, 16'd7, 24'd10, 16'd4));
    set_span(5'd1);
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_SELL, 16'hFFFF, 24'd5,
                    16'hFFFF));
    send(order_beat(obm_pkg::MODE_MATCH, 4'd0, obm_pkg::SIDE_BUY, 16'd7, 24'hFFFFFF, 16'd2));

    // random phases, each with its own span, products and price band
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       set_span(5'($urandom_range(1, 15)));
        2:       set_span(5'd0);
        5:       set_span(5'd31);
        6:       set_span(5'($urandom_range(17, 31)));
        default: set_span(5'd16);
      endcase
      prod_pool[0] = 16'($urandom);
      prod_pool[1] = 16'($urandom);
      price_base   = 24'($urandom_range(0, 24'hFFFF00));
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p < PHASES - 2 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 5));
        send(random_order());
      end
    end

    // drain and report
    settle();
    if (book.due_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, book.due_results.size());
      book.errors++;
    end
    $display("Ran %0d loads and %0d matches: %0d fills, %0d orders filled completely",
             book.loads, book.match_count, book.fills, book.filled_orders);
    $display("Walk spans covered 0, 1, 16, 31 and random values; %0d mismatches",
             book.errors);
    if (book.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: files.f
design/obm_pkg.sv
design/obm_table.sv
design/obm_fill.sv
design/order_book_match_unit.sv
sim/tb_order_book_match_unit.sv
